### rtl/core/lpse_pkg.sv
// ----------------------------------------------------------------------------
// lpse_pkg: shared types, constants and helpers
// Payload structs, register map and the small arithmetic helpers used by
// the LED pixel SPI encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

    // one input pixel
    typedef struct packed {
        logic        mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
        logic        last_pixel;
    } t_pixel_in;

    // one result byte
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last;
    } t_spi_out;

    // finished colour handed to the serialiser
    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last_pixel;
    } t_rgb;

    localparam logic MODE_HSB = 1'b1;

    // register map, one 32-bit word each
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SYMBOL_00 = 2'd0,
        REG_SYMBOL_01 = 2'd1,
        REG_SYMBOL_10 = 2'd2,
        REG_SYMBOL_11 = 2'd3
    } t_reg_idx;

    localparam logic [7:0] SYMBOL_00_RST = 8'h88;
    localparam logic [7:0] SYMBOL_01_RST = 8'h8E;
    localparam logic [7:0] SYMBOL_10_RST = 8'hE8;
    localparam logic [7:0] SYMBOL_11_RST = 8'hEE;

    // bit pair codes
    localparam logic [1:0] PAIR_00 = 2'b00;
    localparam logic [1:0] PAIR_01 = 2'b01;
    localparam logic [1:0] PAIR_10 = 2'b10;
    localparam logic [1:0] PAIR_11 = 2'b11;

    // hue segments
    localparam logic [1:0] SEG_RED_GREEN  = 2'd0;
    localparam logic [1:0] SEG_GREEN_BLUE = 2'd1;
    localparam logic [1:0] SEG_BLUE_RED   = 2'd2;

    // byte schedule of one pixel
    localparam logic [3:0] SYMBOL_BYTES = 4'd12;  // 3 channels x 4 pairs
    localparam logic [3:0] GAP_BYTE     = 4'd12;  // trailing zero byte
    localparam logic [3:0] LATCH_BYTE   = 4'd13;  // extra zero on last pixel

    localparam logic [7:0] FULL_SCALE = 8'd255;

    // x mod 3 for a byte: 4 = 1 (mod 3), so fold base-4 digits
    function automatic logic [1:0] mod3_byte(input logic [7:0] x);
        logic [3:0] s;
        logic [2:0] t;
        logic [2:0] r;
        s = 4'(x[7:6]) + 4'(x[5:4]) + 4'(x[3:2]) + 4'(x[1:0]);
        t = 3'(s[3:2]) + 3'(s[1:0]);
        priority if (t >= 3'd6) begin
            r = t - 3'd6;
        end else if (t >= 3'd3) begin
            r = t - 3'd3;
        end else begin
            r = t;
        end
        return r[1:0];
    endfunction

    // floor(x / 255), exact for x <= 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

### rtl/core/lpse_hsb_pipe.sv
// ----------------------------------------------------------------------------
// lpse_hsb_pipe: colour pipeline
// Five register stages: hue split, saturation product, white mix,
// brightness product, final scale and direct-colour select.
// ----------------------------------------------------------------------------
module lpse_hsb_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pix_valid,
    input  lpse_pkg::t_pixel_in i_pix,
    output logic               o_pix_stall,
    output logic               o_rgb_valid,
    output lpse_pkg::t_rgb     o_rgb,
    input  logic               i_rgb_stall
);
    import lpse_pkg::*;

    // channel lanes: 0 red, 1 green, 2 blue
    localparam int unsigned CH_R = 0;
    localparam int unsigned CH_G = 1;
    localparam int unsigned CH_B = 2;

    // payload carried alongside the arithmetic
    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic       last_pixel;
    } t_side;

    logic              r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic              rdy1, rdy2, rdy3, rdy4, rdy5;
    t_side             r_s1_side, r_s2_side, r_s3_side, r_s4_side;
    logic [2:0][7:0]   r_s1_c, n_s1_c;
    logic [2:0][15:0]  r_s2_p;
    logic [2:0][7:0]   r_s3_v;
    logic [2:0][15:0]  r_s4_q;
    t_rgb              r_s5_rgb, n_s5_rgb;
    t_side             n_s1_side;
    logic [1:0]        seg;
    logic [7:0]        pos;

    // ready ripples back from the output
    assign rdy5 = !r_s5_valid || !i_rgb_stall;
    assign rdy4 = !r_s4_valid || rdy5;
    assign rdy3 = !r_s3_valid || rdy4;
    assign rdy2 = !r_s2_valid || rdy3;
    assign rdy1 = !r_s1_valid || rdy2;

    assign o_pix_stall = !rdy1;
    assign o_rgb_valid = r_s5_valid;
    assign o_rgb       = r_s5_rgb;

    // stage 1: hue mod 768 into segment and position
    always_comb begin
        seg = mod3_byte(i_pix.hue[15:8]);
        pos = i_pix.hue[7:0];
        unique case (seg)
            SEG_GREEN_BLUE: begin
                n_s1_c[CH_R] = 8'd0;
                n_s1_c[CH_G] = FULL_SCALE - pos;
                n_s1_c[CH_B] = pos;
            end
            SEG_BLUE_RED: begin
                n_s1_c[CH_R] = pos;
                n_s1_c[CH_G] = 8'd0;
                n_s1_c[CH_B] = FULL_SCALE - pos;
            end
            default: begin
                n_s1_c[CH_R] = FULL_SCALE - pos;
                n_s1_c[CH_G] = pos;
                n_s1_c[CH_B] = 8'd0;
            end
        endcase
        n_s1_side.mode       = i_pix.mode;
        n_s1_side.red        = i_pix.red;
        n_s1_side.green      = i_pix.green;
        n_s1_side.blue       = i_pix.blue;
        n_s1_side.saturation = i_pix.saturation;
        n_s1_side.brightness = i_pix.brightness;
        n_s1_side.last_pixel = i_pix.last_pixel;
    end

    // stage 5: final scale or direct colour
    always_comb begin
        if (r_s4_side.mode == MODE_HSB) begin
            n_s5_rgb.red   = div255(r_s4_q[CH_R]);
            n_s5_rgb.green = div255(r_s4_q[CH_G]);
            n_s5_rgb.blue  = div255(r_s4_q[CH_B]);
        end else begin
            n_s5_rgb.red   = r_s4_side.red;
            n_s5_rgb.green = r_s4_side.green;
            n_s5_rgb.blue  = r_s4_side.blue;
        end
        n_s5_rgb.last_pixel = r_s4_side.last_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (rdy1) r_s1_valid <= i_pix_valid;
            if (rdy2) r_s2_valid <= r_s1_valid;
            if (rdy3) r_s3_valid <= r_s2_valid;
            if (rdy4) r_s4_valid <= r_s3_valid;
            if (rdy5) r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_c    <= n_s1_c;
            r_s1_side <= n_s1_side;
        end
        if (rdy2) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_p[i] <= 16'(r_s1_c[i]) * 16'(r_s1_side.saturation);
            end
            r_s2_side <= r_s1_side;
        end
        if (rdy3) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_v[i] <= div255(r_s2_p[i]) + (FULL_SCALE - r_s2_side.saturation);
            end
            r_s3_side <= r_s2_side;
        end
        if (rdy4) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_q[i] <= 16'(r_s3_v[i]) * 16'(r_s3_side.brightness);
            end
            r_s4_side <= r_s3_side;
        end
        if (rdy5) begin
            r_s5_rgb <= n_s5_rgb;
        end
    end

endmodule

### rtl/core/led_pixel_spi_encoder.sv
// ----------------------------------------------------------------------------
// led_pixel_spi_encoder: LED pixel to SPI byte stream
// Pixels come in as direct red/green/blue or as hue/saturation/brightness
// and leave as SPI bytes, one byte per output transfer: for each pixel four
// symbol bytes each for green, red and blue (bit pairs, most significant
// first, through the programmable symbol table), then one zero byte, plus a
// zero latch byte after a pixel flagged last_pixel. The final byte of every
// pixel carries last. A pixel is 13 bytes, 14 when it ends the frame. The
// serialiser drives one byte per cycle while i_spi_stall is low. Ahead of
// it a five-stage colour pipeline takes a new pixel every cycle until it
// fills. The symbol registers sit on an APB port at byte addresses 0, 4,
// 8 and 12 and reset to 0x88, 0x8E, 0xE8, 0xEE; write them only while the
// block is idle.
// ----------------------------------------------------------------------------
module led_pixel_spi_encoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel input
    input  logic                                 i_pix_valid,
    input  lpse_pkg::t_pixel_in                  i_pix,
    output logic                                 o_pix_stall,
    // SPI byte output
    output logic                                 o_spi_valid,
    output lpse_pkg::t_spi_out                   o_spi,
    input  logic                                 i_spi_stall,
    // APB register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lpse_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lpse_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lpse_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import lpse_pkg::*;

    // symbol table
    logic [7:0] r_sym_00, r_sym_01, r_sym_10, r_sym_11;
    t_reg_idx   reg_idx;
    logic       cfg_wr;
    logic [7:0] rd_sym;

    // pipeline to serialiser
    logic       rgb_valid;
    t_rgb       rgb;
    logic       rgb_take;

    // serialiser: holds one pixel and walks its bytes
    logic        r_ser_valid;
    logic [23:0] r_ser_bits;   // {green, red, blue}, shifted left a pair per byte
    logic [3:0]  r_ser_cnt;    // byte number within the pixel
    logic        r_ser_latch;  // pixel ends the frame
    logic        ser_final;
    logic        spi_xfer;
    logic [7:0]  pair_sym;

    // ------------------------------------------------------------------
    // Register port: no wait states, index from the word address
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_SYMBOL_00: rd_sym = r_sym_00;
            REG_SYMBOL_01: rd_sym = r_sym_01;
            REG_SYMBOL_10: rd_sym = r_sym_10;
            REG_SYMBOL_11: rd_sym = r_sym_11;
            default:       rd_sym = r_sym_00;
        endcase
    end
    assign prdata = APB_DATA_W'(rd_sym);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_00 <= SYMBOL_00_RST;
            r_sym_01 <= SYMBOL_01_RST;
            r_sym_10 <= SYMBOL_10_RST;
            r_sym_11 <= SYMBOL_11_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SYMBOL_00: r_sym_00 <= pwdata[7:0];
                REG_SYMBOL_01: r_sym_01 <= pwdata[7:0];
                REG_SYMBOL_10: r_sym_10 <= pwdata[7:0];
                REG_SYMBOL_11: r_sym_11 <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Colour pipeline
    // ------------------------------------------------------------------
    lpse_hsb_pipe u_hsb_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .i_pix       (i_pix),
        .o_pix_stall (o_pix_stall),
        .o_rgb_valid (rgb_valid),
        .o_rgb       (rgb),
        .i_rgb_stall (!rgb_take)
    );

    // ------------------------------------------------------------------
    // Serialiser
    // The last byte of a pixel is the gap byte, or the latch byte when
    // the pixel closes the frame. A new pixel loads in the same cycle the
    // final byte transfers, so pixels follow with no idle byte.
    // ------------------------------------------------------------------
    assign ser_final = r_ser_latch ? (r_ser_cnt == LATCH_BYTE) : (r_ser_cnt == GAP_BYTE);
    assign spi_xfer  = r_ser_valid && !i_spi_stall;
    assign rgb_take  = !r_ser_valid || (spi_xfer && ser_final);

    always_comb begin
        unique case (r_ser_bits[23:22])
            PAIR_00: pair_sym = r_sym_00;
            PAIR_01: pair_sym = r_sym_01;
            PAIR_10: pair_sym = r_sym_10;
            PAIR_11: pair_sym = r_sym_11;
            default: pair_sym = r_sym_00;
        endcase
    end

    // symbol bytes first, zeros after
    assign o_spi_valid    = r_ser_valid;
    assign o_spi.spi_byte = (r_ser_cnt < SYMBOL_BYTES) ? pair_sym : 8'd0;
    assign o_spi.last     = ser_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_ser_cnt   <= 4'd0;
        end else if (rgb_take) begin
            r_ser_valid <= rgb_valid;
            r_ser_cnt   <= 4'd0;
        end else if (spi_xfer) begin
            r_ser_cnt   <= r_ser_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rgb_take) begin
            r_ser_bits  <= {rgb.green, rgb.red, rgb.blue};
            r_ser_latch <= rgb.last_pixel;
        end else if (spi_xfer) begin
            r_ser_bits  <= {r_ser_bits[21:0], 2'b00};
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for led_pixel_spi_encoder
// Streams direct and hue/saturation/brightness pixels through the encoder
// under several symbol tables and flow-control patterns. Every SPI byte is
// checked against a local colour predictor and byte serialiser.
// ----------------------------------------------------------------------------
module testbench;
    import lpse_pkg::*;

    localparam int unsigned CLK_HALF_NS    = 2;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned SETTLE_CYCLES  = 24;    // pipeline depth plus margin
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
    localparam int unsigned PHASE_ITEMS    = 72;
    localparam int unsigned NUM_PHASES     = 5;
    localparam int unsigned NUM_DIRECTED   = 20;
    localparam int unsigned HUE_PERIOD     = 768;
    localparam int unsigned HUE_SEGMENT    = 256;
    localparam int unsigned LEVEL_MAX      = 255;

    // one row of the directed table; known rows carry the colour to expect
    typedef struct packed {
        logic        mode;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  bright;
        logic        lastp;
        logic        known;
        logic [7:0]  kg;
        logic [7:0]  kr;
        logic [7:0]  kb;
    } t_dir_row;

    // a pixel waiting to be sent, with an optional fixed colour
    typedef struct {
        t_pixel_in pix;
        bit        known;
        t_rgb      colour;
    } t_pix_job;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_pix_valid = 1'b0;
    t_pixel_in             i_pix = '0;
    logic                  o_pix_stall;
    logic                  o_spi_valid;
    t_spi_out              o_spi;
    logic                  i_spi_stall = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    led_pixel_spi_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .i_pix       (i_pix),
        .o_pix_stall (o_pix_stall),
        .o_spi_valid (o_spi_valid),
        .o_spi       (o_spi),
        .i_spi_stall (i_spi_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Bench-side copy of the symbol table, updated at the write edge
    logic [7:0]  sym_copy [4] = '{SYMBOL_00_RST, SYMBOL_01_RST, SYMBOL_10_RST,
                                  SYMBOL_11_RST};
    t_pix_job    pix_jobs [$];      // pixels still to be offered
    t_spi_out    spi_due [$];       // bytes the encoder owes us, oldest first
    t_pix_job    job_now;           // pixel currently on the input port
    int unsigned send_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned pixels_taken = 0;
    int unsigned frame_ends = 0;
    int unsigned bytes_seen = 0;
    int unsigned tables_used = 1;
    int unsigned quiet_cycles = 0;

    // Directed rows: extremes of every field, segment edges of the hue
    // wheel, hue wrap, white and black, ignored fields carrying junk.
    //                 mode   red    green  blue   hue       sat    bright last known  g      r      b
    t_dir_row directed_rows [NUM_DIRECTED] = '{
        '{1'b0, 8'd0,   8'd0,   8'd0,   16'd0,     8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd255, 8'd255, 8'd255, 16'd65535, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255},
        '{1'b0, 8'h1B,  8'hE4,  8'h55,  16'h1234,  8'd17,  8'd99,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'hAA,  8'h55,  8'hC3,  16'hFFFF,  8'd255, 8'd0,   1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd0,     8'd255, 8'd255, 1'b0, 1'b1, 8'd0,   8'd255, 8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd256,   8'd255, 8'd255, 1'b0, 1'b1, 8'd255, 8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd512,   8'd255, 8'd255, 1'b0, 1'b1, 8'd0,   8'd0,   8'd255},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd768,   8'd255, 8'd255, 1'b1, 1'b1, 8'd0,   8'd255, 8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd767,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd65535, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd255,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd511,   8'd255, 8'd255, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd300,   8'd0,   8'd255, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd100,   8'd77,  8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd600,   8'd0,   8'd0,   1'b1, 1'b1, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd255, 8'd255, 8'd255, 16'd128,   8'd128, 8'd128, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'h5A,  8'hA5,  8'h3C,  16'd40000, 8'd200, 8'd60,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd1,     8'd1,   8'd254, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b0, 8'd1,   8'd128, 8'd254, 16'd0,     8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{1'b1, 8'd0,   8'd0,   8'd0,   16'd65280, 8'd255, 8'd255, 1'b1, 1'b1, 8'd0,   8'd255, 8'd0}
    };

    initial begin : clock_gen
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Colour predictor: white mix by saturation, then brightness scale.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] shade(int unsigned c, int unsigned sat,
                                         int unsigned bright);
        int unsigned v;
        v = (c * sat) / LEVEL_MAX + (LEVEL_MAX - sat);
        return 8'((v * bright) / LEVEL_MAX);
    endfunction

    function automatic t_rgb pixel_colour(t_pixel_in p);
        t_rgb        c;
        int unsigned h;
        int unsigned pos;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        logic [1:0]  seg;
        c.last_pixel = p.last_pixel;
        if (p.mode == MODE_HSB) begin
            h   = p.hue % HUE_PERIOD;
            pos = h % HUE_SEGMENT;
            seg = 2'(h / HUE_SEGMENT);
            case (seg)
                SEG_RED_GREEN: begin
                    r = LEVEL_MAX - pos; g = pos; b = 0;
                end
                SEG_GREEN_BLUE: begin
                    r = 0; g = LEVEL_MAX - pos; b = pos;
                end
                default: begin
                    r = pos; g = 0; b = LEVEL_MAX - pos;
                end
            endcase
            c.red   = shade(r, p.saturation, p.brightness);
            c.green = shade(g, p.saturation, p.brightness);
            c.blue  = shade(b, p.saturation, p.brightness);
        end else begin
            c.red   = p.red;
            c.green = p.green;
            c.blue  = p.blue;
        end
        return c;
    endfunction

    // Serialise a colour into the bytes owed: G, R, B, MS pair first,
    // then the gap byte and, at frame end, the latch byte.
    task automatic push_pixel_bytes(t_rgb c);
        logic [7:0] lanes [3];
        logic [1:0] pair;
        t_spi_out   b;
        lanes = '{c.green, c.red, c.blue};
        for (int ch = 0; ch < 3; ch++) begin
            for (int s = 3; s >= 0; s--) begin
                pair       = lanes[ch][2*s +: 2];
                b.spi_byte = sym_copy[pair];
                b.last     = 1'b0;
                spi_due.push_back(b);
            end
        end
        b.spi_byte = 8'h00;
        b.last     = ~c.last_pixel;
        spi_due.push_back(b);
        if (c.last_pixel) begin
            b.last = 1'b1;
            spi_due.push_back(b);
        end
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("[%0t] %s wrong on byte %0d: got 0x%0h, want 0x%0h",
                 $realtime, field, bytes_seen, got, want);
        mismatches++;
    endtask

    // Random pixel, biased towards segment edges and saturation extremes
    function automatic t_pixel_in random_pixel();
        t_pixel_in p;
        p.mode  = 1'($urandom_range(0, 1));
        p.red   = 8'($urandom);
        p.green = 8'($urandom);
        p.blue  = 8'($urandom);
        case ($urandom_range(0, 7))
            0:       p.hue = 16'(HUE_SEGMENT * $urandom_range(0, 3));
            1:       p.hue = 16'(HUE_SEGMENT * $urandom_range(1, 3) - 1);
            2:       p.hue = 16'(HUE_PERIOD * $urandom_range(0, 85) + $urandom_range(0, 2));
            3:       p.hue = 16'($urandom_range(65280, 65535));
            default: p.hue = 16'($urandom);
        endcase
        p.saturation = ($urandom_range(0, 3) == 0) ? 8'(LEVEL_MAX * $urandom_range(0, 1))
                                                  : 8'($urandom);
        p.brightness = ($urandom_range(0, 3) == 0) ? 8'(LEVEL_MAX * $urandom_range(0, 1))
                                                  : 8'($urandom);
        p.last_pixel = ($urandom_range(0, 3) == 0);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel sender: holds the payload while stalled, idles at random otherwise.
    // A transfer is taken from the values present before the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_sender
        t_rgb c;
        if (i_rst_n) begin
            if (i_pix_valid && !o_pix_stall) begin
                c = job_now.known ? job_now.colour : pixel_colour(job_now.pix);
                c.last_pixel = job_now.pix.last_pixel;
                push_pixel_bytes(c);
                pixels_taken++;
                if (job_now.pix.last_pixel) frame_ends++;
            end
            if (!(i_pix_valid && o_pix_stall)) begin
                if (pix_jobs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    job_now = pix_jobs.pop_front();
                    i_pix       <= job_now.pix;
                    i_pix_valid <= 1'b1;
                end else begin
                    i_pix_valid <= 1'b0;
                end
            end
        end
    end

    // SPI byte receiver: checks each transfer against the oldest owed byte
    always @(posedge i_clk) begin : spi_receiver
        t_spi_out want;
        if (i_rst_n) begin
            if (o_spi_valid && !i_spi_stall) begin
                if (spi_due.size() == 0) begin
                    report_mismatch("unexpected spi_byte", o_spi.spi_byte, 0);
                end else begin
                    want = spi_due.pop_front();
                    if (o_spi.spi_byte !== want.spi_byte)
                        report_mismatch("spi_byte", o_spi.spi_byte, want.spi_byte);
                    if (o_spi.last !== want.last)
                        report_mismatch("last", o_spi.last, want.last);
                end
                bytes_seen++;
            end
            i_spi_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side is a hang
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_pix_valid && !o_pix_stall) || (o_spi_valid && !i_spi_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d bytes still owed",
                         quiet_cycles, spi_due.size());
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // APB write: setup, then access until pready; shadow updated at that edge
    task automatic write_symbol(t_reg_idx idx, logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= {24'($urandom), value};   // upper bits are don't-care
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sym_copy[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait, on the falling edge, until nothing is queued, offered or owed
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pix_jobs.size() != 0 || i_pix_valid || spi_due.size() != 0);
    endtask

    task automatic queue_random(int unsigned n);
        t_pix_job job;
        for (int unsigned k = 0; k < n; k++) begin
            job.pix    = random_pixel();
            job.known  = 1'b0;
            job.colour = '0;
            pix_jobs.push_back(job);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases, each with its
    // own symbol table and one of four idle patterns. Mid-phase the sender
    // holds off until every owed byte has arrived.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_dir_row   row;
        t_pix_job   job;
        logic [7:0] table_vals [4];
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part runs on the reset symbol table, no idling
        for (int unsigned k = 0; k < NUM_DIRECTED; k++) begin
            row = directed_rows[k];
            job.pix.mode       = row.mode;
            job.pix.red        = row.red;
            job.pix.green      = row.green;
            job.pix.blue       = row.blue;
            job.pix.hue        = row.hue;
            job.pix.saturation = row.sat;
            job.pix.brightness = row.bright;
            job.pix.last_pixel = row.lastp;
            job.known          = row.known;
            job.colour         = '{green: row.kg, red: row.kr, blue: row.kb,
                                   last_pixel: row.lastp};
            pix_jobs.push_back(job);
        end
        wait_drained();

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            for (int r = 0; r < 4; r++) begin
                case (ph)
                    0:       table_vals[r] = 8'h00;
                    1:       table_vals[r] = 8'hFF;
                    default: table_vals[r] = 8'($urandom);
                endcase
            end
            write_symbol(REG_SYMBOL_00, table_vals[0]);
            write_symbol(REG_SYMBOL_01, table_vals[1]);
            write_symbol(REG_SYMBOL_10, table_vals[2]);
            write_symbol(REG_SYMBOL_11, table_vals[3]);
            tables_used++;
            @(negedge i_clk);
            case (ph % 4)
                0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; rcv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rcv_stall_pct = 50; end
                default: begin send_idle_pct = 9; rcv_stall_pct = 9; end
            endcase
            queue_random(PHASE_ITEMS / 2);
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Run covered %0d pixels (%0d frame ends) and %0d SPI bytes",
                 pixels_taken, frame_ends, bytes_seen);
        $display("over %0d symbol tables and four flow-control patterns", tables_used);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
